// ----- hw/rtl/keypad_code_lock_macros.svh -----
// Assertion helpers shared by the keypad code lock modules.
`ifndef KEYPAD_CODE_LOCK_MACROS_SVH
`define KEYPAD_CODE_LOCK_MACROS_SVH

// Checked only outside reset.
`define KCL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define KCL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/kcl_pkg.sv -----
`default_nettype none

package kcl_pkg;

   localparam int KEY_ROWS    = 4;
   localparam int KEY_COLS    = 3;
   localparam int ENTRY_MAX   = 16;
   localparam int CODE_DIGITS = 6;

   localparam int KEY_ALL     = KEY_ROWS * KEY_COLS;
   localparam int KEY_IN_W    = 12;
   localparam int KEY_SCAN    = (KEY_ALL < KEY_IN_W) ? KEY_ALL : KEY_IN_W;
   localparam int KEY_W       = 4;
   localparam int CNT_W       = 8;
   localparam int DIGIT_W     = 4;
   localparam int CODE_W      = CODE_DIGITS * DIGIT_W;
   localparam int LEN_W       = 3;
   localparam int FAIL_W      = 8;
   localparam int ENTRY_IDX_W = $clog2(ENTRY_MAX);
   localparam int ENTRY_CNT_W = $clog2(ENTRY_MAX + 1);
   localparam int ELEN_W      = 5;
   localparam int CSR_IDX_W   = 3;

   localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
   localparam logic [KEY_W-1:0] KEY_BACK  = 4'd10;
   localparam logic [KEY_W-1:0] KEY_ZERO  = 4'd11;
   localparam logic [KEY_W-1:0] KEY_ENTER = 4'd12;

   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_CODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd5;

   typedef logic [ENTRY_MAX-1:0][DIGIT_W-1:0] digits_type;

   typedef struct packed {
      logic             arm;
      logic [KEY_W-1:0] key;
   } event_type;

   typedef struct packed {
      logic [CODE_W-1:0] main_code;
      logic [LEN_W-1:0]  main_len;
      logic [CODE_W-1:0] temp_code;
      logic [LEN_W-1:0]  temp_len;
      logic [FAIL_W-1:0] fail_limit;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_code;
      logic [ELEN_W-1:0] entry_length;
      logic              unlock;
      logic              temp_code_used;
      logic              attempt_failed;
      logic              alarm;
      logic [FAIL_W-1:0] fail_count;
   } result_type;

   // Code appears as a contiguous run within the first cnt digits; a zero length always hits.
   function automatic logic code_hit(digits_type digits, logic [ENTRY_CNT_W-1:0] cnt,
                                     logic [CODE_W-1:0] code, logic [LEN_W-1:0] len_raw);
      logic [LEN_W-1:0] len;
      logic             hit;
      logic             ok;
      len = (len_raw > LEN_W'(CODE_DIGITS)) ? LEN_W'(CODE_DIGITS) : len_raw;
      hit = (len == '0);
      for (int s = 0; s < ENTRY_MAX; s++) begin
         ok = (len != '0) &&
              ((ENTRY_CNT_W'(s) + (ENTRY_CNT_W + 1)'(len)) <= (ENTRY_CNT_W + 1)'(cnt));
         for (int i = 0; i < CODE_DIGITS; i++) begin
            if (s + i < ENTRY_MAX) begin
               if (LEN_W'(i) < len) begin
                  ok = ok && (digits[s + i] == code[DIGIT_W * i +: DIGIT_W]);
               end
            end
         end
         hit = hit | ok;
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kcl_front.sv -----
`default_nettype none

`include "keypad_code_lock_macros.svh"

module kcl_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire logic                              cmd,
   input  wire logic [kcl_pkg::KEY_IN_W-1:0]      key_pressed,
   input  wire logic [kcl_pkg::CNT_W-1:0]         threshold,
   input  wire logic                              ev_full,
   output logic                                   ev_push,
   output kcl_pkg::event_type                     ev_data
);

   logic [kcl_pkg::KEY_ALL-1:0][kcl_pkg::CNT_W-1:0] cnt_ff;
   logic [kcl_pkg::KEY_ALL-1:0][kcl_pkg::CNT_W-1:0] cnt_in;
   logic [kcl_pkg::KEY_ALL-1:0][kcl_pkg::CNT_W-1:0] bumped;
   logic [kcl_pkg::KEY_ALL-1:0]                     take;
   logic                                            found;
   logic [kcl_pkg::KEY_W-1:0]                       key;
   logic                                            scan;

   assign ev_push = push & ~ev_full;
   assign scan    = ev_push & ~cmd;

   always_comb begin
      found = 1'b0;
      key   = kcl_pkg::KEY_NONE;
      take  = '0;
      for (int k = 0; k < kcl_pkg::KEY_ALL; k++) begin
         bumped[k] = cnt_ff[k];
         if (k < kcl_pkg::KEY_SCAN) begin
            bumped[k] = cnt_ff[k] + kcl_pkg::CNT_W'(key_pressed[k]);
            if (!found && bumped[k] > threshold) begin
               found   = 1'b1;
               take[k] = 1'b1;
               key     = kcl_pkg::KEY_W'(k + 1);
            end
         end
      end
      for (int k = 0; k < kcl_pkg::KEY_ALL; k++) begin
         cnt_in[k] = take[k] ? '0 : bumped[k];
      end
   end

   assign ev_data.arm = cmd;
   assign ev_data.key = cmd ? kcl_pkg::KEY_NONE : key;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (scan) begin
         cnt_ff <= cnt_in;
      end
   end

   `KCL_ASSERT(a_arm_keeps_counters, ev_push && cmd |=> $stable(cnt_ff), "arm beat changed counters")
   `KCL_ASSERT(a_one_key, $onehot0(take), "more than one key taken")
   `KCL_ASSERT(a_no_push_when_full, ev_full |-> !ev_push, "event pushed into full queue")

endmodule

`default_nettype wire

// ----- hw/rtl/kcl_evq.sv -----
`default_nettype none

`include "keypad_code_lock_macros.svh"

module kcl_evq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire kcl_pkg::event_type data_in,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output kcl_pkg::event_type      data_out
);

   kcl_pkg::event_type slot_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         cnt_ff;
   logic [1:0]         cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

   `KCL_ASSERT_ALWAYS(a_cnt_bound, reset || (cnt_ff != 2'd3), "event queue count overflow")
   `KCL_ASSERT(a_no_pop_empty, empty |-> !pop, "event queue popped while empty")
   `KCL_ASSERT(a_ptr_track, (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff), "pointers out of step")

endmodule

`default_nettype wire

// ----- hw/rtl/kcl_back.sv -----
`default_nettype none

`include "keypad_code_lock_macros.svh"

module kcl_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               ev_empty,
   input  wire kcl_pkg::event_type ev_data,
   output logic                    ev_pop,
   input  wire kcl_pkg::cfg_type   cfg,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output kcl_pkg::result_type     rsp_data
);

   kcl_pkg::digits_type                 digits_ff;
   logic [kcl_pkg::ENTRY_CNT_W-1:0]     entry_cnt_ff;
   logic [kcl_pkg::ENTRY_CNT_W-1:0]     entry_cnt_in;
   logic [kcl_pkg::FAIL_W-1:0]          fail_ff;
   logic [kcl_pkg::FAIL_W-1:0]          fail_in;
   logic [kcl_pkg::FAIL_W-1:0]          fail_bump;
   logic                                armed_ff;
   logic                                armed_in;
   logic                                dig_we;
   logic [kcl_pkg::DIGIT_W-1:0]         dig_val;
   logic                                main_hit;
   logic                                temp_hit;
   kcl_pkg::result_type                 res;

   kcl_pkg::result_type                 slot_ff [2];
   logic                                wr_ptr_ff;
   logic                                rd_ptr_ff;
   logic [1:0]                          rcnt_ff;
   logic [1:0]                          rcnt_in;
   logic                                res_pop;

   assign ev_pop  = ~ev_empty & (rcnt_ff != 2'd2);
   assign res_pop = rsp_pop & ~rsp_empty;

   assign main_hit  = kcl_pkg::code_hit(digits_ff, entry_cnt_ff, cfg.main_code, cfg.main_len);
   assign temp_hit  = armed_ff &
                      kcl_pkg::code_hit(digits_ff, entry_cnt_ff, cfg.temp_code, cfg.temp_len);
   assign fail_bump = (fail_ff == '1) ? fail_ff : fail_ff + kcl_pkg::FAIL_W'(1);
   assign dig_val   = (ev_data.key == kcl_pkg::KEY_ZERO) ? '0 : ev_data.key;

   always_comb begin
      entry_cnt_in = entry_cnt_ff;
      fail_in      = fail_ff;
      armed_in     = armed_ff | ev_data.arm;
      dig_we       = 1'b0;
      res          = '0;
      res.key_code = ev_data.key;
      unique case (ev_data.key)
         kcl_pkg::KEY_NONE: begin
         end
         kcl_pkg::KEY_BACK: begin
            if (entry_cnt_ff != '0) begin
               entry_cnt_in = entry_cnt_ff - kcl_pkg::ENTRY_CNT_W'(1);
            end
         end
         kcl_pkg::KEY_ENTER: begin
            entry_cnt_in       = '0;
            res.temp_code_used = temp_hit;
            if (temp_hit) begin
               armed_in = 1'b0;
            end
            if (main_hit || temp_hit) begin
               res.unlock = 1'b1;
               fail_in    = '0;
            end else begin
               res.attempt_failed = 1'b1;
               fail_in            = fail_bump;
               res.alarm          = (fail_bump >= cfg.fail_limit);
            end
         end
         default: begin
            if (entry_cnt_ff == kcl_pkg::ENTRY_CNT_W'(kcl_pkg::ENTRY_MAX)) begin
               entry_cnt_in = '0;
            end else begin
               dig_we       = 1'b1;
               entry_cnt_in = entry_cnt_ff + kcl_pkg::ENTRY_CNT_W'(1);
            end
         end
      endcase
      res.entry_length = kcl_pkg::ELEN_W'(entry_cnt_in);
      res.fail_count   = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_cnt_ff <= '0;
         fail_ff      <= '0;
         armed_ff     <= 1'b0;
      end else if (ev_pop) begin
         entry_cnt_ff <= entry_cnt_in;
         fail_ff      <= fail_in;
         armed_ff     <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop && dig_we) begin
         digits_ff[entry_cnt_ff[kcl_pkg::ENTRY_IDX_W-1:0]] <= dig_val;
      end
   end

   // result queue
   assign rsp_empty = (rcnt_ff == 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      rcnt_in = rcnt_ff;
      if (ev_pop && !res_pop) begin
         rcnt_in = rcnt_ff + 2'd1;
      end else if (res_pop && !ev_pop) begin
         rcnt_in = rcnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         rcnt_ff   <= 2'd0;
      end else begin
         if (ev_pop) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (res_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         rcnt_ff <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         slot_ff[wr_ptr_ff] <= res;
      end
   end

   `KCL_ASSERT_ALWAYS(a_entry_bound,
      reset || (entry_cnt_ff <= kcl_pkg::ENTRY_CNT_W'(kcl_pkg::ENTRY_MAX)), "entry count overflow")
   `KCL_ASSERT(a_verdict_excl, ev_pop |-> !(res.unlock && res.attempt_failed), "both verdicts")
   `KCL_ASSERT(a_alarm_fail, ev_pop && res.alarm |-> res.attempt_failed, "alarm without failure")
   `KCL_ASSERT(a_used_disarms, ev_pop && res.temp_code_used |=> !armed_ff, "temp code still armed")

endmodule

`default_nettype wire

// ----- hw/rtl/keypad_code_lock.sv -----
// Keypad code lock. Scan beats (req_cmd 0) carry the 4x3 pressed-key bits; arm beats
// (req_cmd 1) arm the one-use temporary code. Every accepted beat yields exactly one
// result beat, in order. One beat per clock is taken while the results are popped; a
// result is poppable once it has passed the front scan stage, the event queue and the
// back stage into a two-entry result queue. req_full rises only when the result side
// stalls. csr_ready is always high; write registers only while no result is pending.
`default_nettype none

module keypad_code_lock (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_cmd,
   input  wire logic [kcl_pkg::KEY_IN_W-1:0]        req_key_pressed,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [kcl_pkg::KEY_W-1:0]                rsp_key_code,
   output logic [kcl_pkg::ELEN_W-1:0]               rsp_entry_length,
   output logic                                     rsp_unlock,
   output logic                                     rsp_temp_code_used,
   output logic                                     rsp_attempt_failed,
   output logic                                     rsp_alarm,
   output logic [kcl_pkg::FAIL_W-1:0]               rsp_fail_count,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [kcl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [kcl_pkg::CODE_W-1:0]          csr_wdata
);

   kcl_pkg::cfg_type           cfg_ff;
   logic [kcl_pkg::CNT_W-1:0]  thr_ff;
   logic                       csr_we;
   logic                       ev_full;
   logic                       ev_push;
   logic                       ev_empty;
   logic                       ev_pop;
   kcl_pkg::event_type         ev_in;
   kcl_pkg::event_type         ev_out;
   kcl_pkg::result_type        rsp_data;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;
   assign req_full  = ev_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_code  <= '0;
         cfg_ff.main_len   <= '0;
         cfg_ff.temp_code  <= '0;
         cfg_ff.temp_len   <= '0;
         cfg_ff.fail_limit <= kcl_pkg::FAIL_W'(3);
         thr_ff            <= kcl_pkg::CNT_W'(10);
      end else if (csr_we) begin
         unique case (csr_index)
            kcl_pkg::CSR_MAIN_CODE:  cfg_ff.main_code  <= csr_wdata;
            kcl_pkg::CSR_MAIN_LEN:   cfg_ff.main_len   <= csr_wdata[kcl_pkg::LEN_W-1:0];
            kcl_pkg::CSR_TEMP_CODE:  cfg_ff.temp_code  <= csr_wdata;
            kcl_pkg::CSR_TEMP_LEN:   cfg_ff.temp_len   <= csr_wdata[kcl_pkg::LEN_W-1:0];
            kcl_pkg::CSR_FAIL_LIMIT: cfg_ff.fail_limit <= csr_wdata[kcl_pkg::FAIL_W-1:0];
            kcl_pkg::CSR_THRESHOLD:  thr_ff            <= csr_wdata[kcl_pkg::CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   kcl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .cmd         (req_cmd),
      .key_pressed (req_key_pressed),
      .threshold   (thr_ff),
      .ev_full     (ev_full),
      .ev_push     (ev_push),
      .ev_data     (ev_in)
   );

   kcl_evq u_evq (
      .clock    (clock),
      .reset    (reset),
      .push     (ev_push),
      .data_in  (ev_in),
      .full     (ev_full),
      .pop      (ev_pop),
      .empty    (ev_empty),
      .data_out (ev_out)
   );

   kcl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_empty  (ev_empty),
      .ev_data   (ev_out),
      .ev_pop    (ev_pop),
      .cfg       (cfg_ff),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_key_code       = rsp_data.key_code;
   assign rsp_entry_length   = rsp_data.entry_length;
   assign rsp_unlock         = rsp_data.unlock;
   assign rsp_temp_code_used = rsp_data.temp_code_used;
   assign rsp_attempt_failed = rsp_data.attempt_failed;
   assign rsp_alarm          = rsp_data.alarm;
   assign rsp_fail_count     = rsp_data.fail_count;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

import kcl_pkg::*;

class lock_scoreboard;
   logic [CODE_W-1:0]  main_code;
   logic [LEN_W-1:0]   main_len;
   logic [CODE_W-1:0]  temp_code;
   logic [LEN_W-1:0]   temp_len;
   logic [FAIL_W-1:0]  fail_limit;
   logic [CNT_W-1:0]   threshold;
   logic [CNT_W-1:0]   key_cnt[KEY_ALL];
   logic [DIGIT_W-1:0] digits[ENTRY_MAX];
   int unsigned        entry_cnt;
   logic [FAIL_W-1:0]  fails;
   bit                 armed;
   result_type         outcome_q[$];
   int                 errors;

   function new();
      main_code  = '0;
      main_len   = '0;
      temp_code  = '0;
      temp_len   = '0;
      fail_limit = 8'd3;
      threshold  = 8'd10;
      foreach (key_cnt[k]) key_cnt[k] = '0;
      foreach (digits[i]) digits[i] = '0;
      entry_cnt = 0;
      fails     = '0;
      armed     = 1'b0;
      errors    = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
      case (idx)
         CSR_MAIN_CODE:  main_code  = data;
         CSR_MAIN_LEN:   main_len   = data[LEN_W-1:0];
         CSR_TEMP_CODE:  temp_code  = data;
         CSR_TEMP_LEN:   temp_len   = data[LEN_W-1:0];
         CSR_FAIL_LIMIT: fail_limit = data[FAIL_W-1:0];
         CSR_THRESHOLD:  threshold  = data[CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function bit code_found(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len_raw);
      int unsigned len;
      bit          hit;
      len = (len_raw > CODE_DIGITS) ? CODE_DIGITS : len_raw;
      if (len == 0) return 1'b1;
      for (int unsigned s = 0; s + len <= entry_cnt; s++) begin
         hit = 1'b1;
         for (int unsigned i = 0; i < len; i++) begin
            if (digits[s + i] != code[DIGIT_W * i +: DIGIT_W]) hit = 1'b0;
         end
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the lock state by one accepted beat; returns the key taken.
   function logic [KEY_W-1:0] note_scan(logic cmd, logic [KEY_IN_W-1:0] keys);
      result_type       r;
      logic [KEY_W-1:0] key;
      bit               main_hit;
      bit               temp_hit;
      r   = '0;
      key = KEY_NONE;
      if (cmd) begin
         armed = 1'b1;
      end else begin
         for (int k = 0; k < KEY_SCAN; k++) begin
            if (keys[k]) key_cnt[k] = key_cnt[k] + 8'd1;
         end
         for (int k = 0; k < KEY_SCAN; k++) begin
            if (key == KEY_NONE && key_cnt[k] > threshold) begin
               key_cnt[k] = '0;
               key = KEY_W'(k + 1);
            end
         end
      end
      if (key == KEY_BACK) begin
         if (entry_cnt > 0) entry_cnt--;
      end else if (key == KEY_ENTER) begin
         main_hit = code_found(main_code, main_len);
         temp_hit = armed && code_found(temp_code, temp_len);
         if (temp_hit) begin
            armed = 1'b0;
            r.temp_code_used = 1'b1;
         end
         if (main_hit || temp_hit) begin
            r.unlock = 1'b1;
            fails = '0;
         end else begin
            r.attempt_failed = 1'b1;
            if (fails != 8'hFF) fails++;
            if (fails >= fail_limit) r.alarm = 1'b1;
         end
         entry_cnt = 0;
      end else if (key != KEY_NONE) begin
         if (entry_cnt >= ENTRY_MAX) begin
            entry_cnt = 0;
         end else begin
            digits[entry_cnt] = (key == KEY_ZERO) ? 4'd0 : key;
            entry_cnt++;
         end
      end
      r.key_code     = key;
      r.entry_length = ELEN_W'(entry_cnt);
      r.fail_count   = fails;
      outcome_q.push_back(r);
      return key;
   endfunction

   function void report(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   function void check_outcome(result_type got);
      result_type want;
      if (outcome_q.size() == 0) begin
         errors++;
         $display("%0t: beat with none pending, key_code expected none actual %0d",
                  $time, got.key_code);
         return;
      end
      want = outcome_q.pop_front();
      report("key_code", want.key_code, got.key_code);
      report("entry_length", want.entry_length, got.entry_length);
      report("unlock", want.unlock, got.unlock);
      report("temp_code_used", want.temp_code_used, got.temp_code_used);
      report("attempt_failed", want.attempt_failed, got.attempt_failed);
      report("alarm", want.alarm, got.alarm);
      report("fail_count", want.fail_count, got.fail_count);
   endfunction

   function int pending();
      return outcome_q.size();
   endfunction
endclass

module tb_top;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_cmd = 1'b0;
   logic [KEY_IN_W-1:0]   req_key_pressed = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [KEY_W-1:0]      rsp_key_code;
   logic [ELEN_W-1:0]     rsp_entry_length;
   logic                  rsp_unlock;
   logic                  rsp_temp_code_used;
   logic                  rsp_attempt_failed;
   logic                  rsp_alarm;
   logic [FAIL_W-1:0]     rsp_fail_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CODE_W-1:0]     csr_wdata = '0;

   lock_scoreboard   sb = new();
   bit               idle_on = 1'b1;
   bit               hold_rsp = 1'b0;
   int               beats = 0;
   logic [KEY_W-1:0] last_key = KEY_NONE;

   keypad_code_lock u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_cmd            (req_cmd),
      .req_key_pressed    (req_key_pressed),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_key_code       (rsp_key_code),
      .rsp_entry_length   (rsp_entry_length),
      .rsp_unlock         (rsp_unlock),
      .rsp_temp_code_used (rsp_temp_code_used),
      .rsp_attempt_failed (rsp_attempt_failed),
      .rsp_alarm          (rsp_alarm),
      .rsp_fail_count     (rsp_fail_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      result_type got;
      int         stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.key_code       = rsp_key_code;
            got.entry_length   = rsp_entry_length;
            got.unlock         = rsp_unlock;
            got.temp_code_used = rsp_temp_code_used;
            got.attempt_failed = rsp_attempt_failed;
            got.alarm          = rsp_alarm;
            got.fail_count     = rsp_fail_count;
            sb.check_outcome(got);
         end
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall = 200;
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 18) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // push stays high after a beat; the next call or wait_idle decides what follows
   task automatic push_beat(input logic cmd, input logic [KEY_IN_W-1:0] keys);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_cmd         <= cmd;
      req_key_pressed <= keys;
      do @(posedge clock); while (req_full);
      last_key = sb.note_scan(cmd, keys);
      beats++;
   endtask

   task automatic press_key(input logic [KEY_W-1:0] code);
      int tries;
      tries = 0;
      do begin
         push_beat(1'b0, KEY_IN_W'(1) << (code - 1));
         tries++;
      end while (last_key != code && tries < 300);
   endtask

   task automatic press_digit(input int d);
      press_key(d == 0 ? KEY_ZERO : KEY_W'(d));
   endtask

   task automatic noise(input int n);
      repeat (n) begin
         push_beat($urandom_range(0, 5) == 0,
                   $urandom_range(0, 2) == 0 ? KEY_IN_W'($urandom)
                                             : KEY_IN_W'(1) << $urandom_range(0, KEY_IN_W - 1));
      end
   endtask

   task automatic try_code(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len_raw);
      int len;
      int d;
      len = (len_raw > CODE_DIGITS) ? CODE_DIGITS : len_raw;
      if (len == 0) len = $urandom_range(1, CODE_DIGITS);
      repeat ($urandom_range(0, 3)) press_digit($urandom_range(0, 9));
      for (int i = 0; i < len; i++) begin
         d = code[DIGIT_W * i +: DIGIT_W];
         if (d > 9 || $urandom_range(0, 19) == 0) d = $urandom_range(0, 9);
         press_digit(d);
         if ($urandom_range(0, 15) == 0) begin
            press_key(KEY_BACK);
            press_digit(d);
         end
      end
      repeat ($urandom_range(0, 2)) press_digit($urandom_range(0, 9));
      press_key(KEY_ENTER);
   endtask

   task automatic run_mix(input int n);
      int stop;
      int pick;
      stop = beats + n;
      while (beats < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            try_code(sb.main_code, sb.main_len);
         end else if (pick < 55) begin
            if ($urandom_range(0, 3) != 0) push_beat(1'b1, KEY_IN_W'($urandom));
            try_code(sb.temp_code, sb.temp_len);
         end else if (pick < 65) begin
            repeat ($urandom_range(14, 20)) press_digit($urandom_range(0, 9));
            press_key(KEY_ENTER);
         end else if (pick < 85) begin
            noise($urandom_range(1, 6));
         end else begin
            repeat ($urandom_range(1, 3)) press_key(KEY_BACK);
            press_key(KEY_ENTER);
         end
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic program_lock(input logic [CODE_W-1:0] mc, input int ml,
                               input logic [CODE_W-1:0] tc, input int tl,
                               input int lim, input int thr);
      wait_idle();
      set_csr(CSR_MAIN_CODE, mc);
      set_csr(CSR_MAIN_LEN, CODE_W'(ml));
      set_csr(CSR_TEMP_CODE, tc);
      set_csr(CSR_TEMP_LEN, CODE_W'(tl));
      set_csr(CSR_FAIL_LIMIT, CODE_W'(lim));
      set_csr(CSR_THRESHOLD, CODE_W'(thr));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CODE_W-1:0] rand_code();
      logic [CODE_W-1:0] c;
      for (int i = 0; i < CODE_DIGITS; i++) c[DIGIT_W * i +: DIGIT_W] = $urandom_range(0, 9);
      return c;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: empty codes, arm ignores the key bits
      push_beat(1'b0, '0);
      push_beat(1'b1, '1);

      // main 1234, temp 905
      program_lock(24'h004321, 4, 24'h000509, 3, 2, 0);
      press_key(KEY_BACK);
      press_key(KEY_ENTER);
      for (int d = 1; d <= 4; d++) press_digit(d);
      press_key(KEY_ENTER);
      press_digit(9); press_digit(0); press_digit(5);
      press_key(KEY_ENTER);
      press_digit(9); press_digit(0); press_digit(5);
      press_key(KEY_ENTER);
      press_key(KEY_ENTER);
      push_beat(1'b0, '1);

      program_lock(rand_code(), 4, rand_code(), 3, 3, 0);
      hold_rsp = 1'b1;
      run_mix(100);
      program_lock(rand_code(), 6, rand_code(), 6, 1, 1);
      run_mix(100);
      program_lock(rand_code(), 0, rand_code(), 7, 255, 0);
      run_mix(60);
      program_lock(CODE_W'($urandom), 7, CODE_W'($urandom), $urandom_range(1, 6), 0, 2);
      run_mix(60);

      // no key can be taken at threshold 255; counters wrap
      program_lock(rand_code(), 5, rand_code(), 2, 255, 255);
      noise(40);
      program_lock(rand_code(), 3, rand_code(), 4, 5, 254);
      repeat (258) push_beat(1'b0, '1);

      // nothing can match: failure count saturates
      program_lock(24'hFFFFFF, 6, 24'hFFFFFF, 6, 255, 0);
      push_beat(1'b1, '0);
      repeat (260) press_key(KEY_ENTER);

      program_lock(rand_code(), $urandom_range(1, 6), rand_code(), $urandom_range(0, 6),
                   $urandom_range(1, 8), $urandom_range(0, 1));
      run_mix(60);
      idle_on = 1'b0;
      run_mix(100);

      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0 && rsp_empty) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
